[rtl/lateral_safe_distance_check_defines.svh]
// Assertion macros for the lateral safe distance check.
`ifndef LATERAL_SAFE_DISTANCE_CHECK_DEFINES_SVH
`define LATERAL_SAFE_DISTANCE_CHECK_DEFINES_SVH
`ifndef SYNTH
`define LSDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsdc assertion failed");
`define LSDC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsdc assertion failed");
`else
`define LSDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LSDC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/lsdc_pkg.sv]
`timescale 1ns / 1ps
package lsdc_pkg;
  localparam int VEL_W  = 16;
  localparam int GAP_W  = 24;
  localparam int ACC_W  = 13;
  localparam int RT_W   = 10;
  localparam int SQ_W   = 2 * VEL_W - 1;
  localparam int DEN_W  = ACC_W + 1;
  localparam int PROD_W = VEL_W + RT_W + 1;
  localparam int VT_W   = PROD_W - 8;
  localparam int MAG_W  = GAP_W;
  localparam int NEED_W = SQ_W + 2;
  localparam logic [SQ_W-1:0] TERM_MAX = SQ_W'(1 << 29);
  localparam logic [RT_W-1:0] RT_RESET = RT_W'(256);

  localparam logic CFG_RT_OTHER = 1'b0;
  localparam logic CFG_RT_EGO   = 1'b1;

  typedef enum logic [1:0] {
    PATH_ZERO    = 2'd0,
    PATH_APART   = 2'd1,
    PATH_FORMULA = 2'd2
  } path_t;

  typedef struct packed {
    path_t                    path;
    logic                     safe;
    logic [MAG_W-1:0]         mag;
    logic signed [VT_W-1:0]   vt1;
    logic signed [VT_W-1:0]   vt2;
    logic                     zv1;
    logic                     za1;
    logic                     zv2;
    logic                     za2;
  } side_t;
endpackage

[rtl/lsdc_div.sv]
`timescale 1ns / 1ps
module lsdc_div #(
  parameter int NUM_W = lsdc_pkg::SQ_W,
  parameter int DEN_W = lsdc_pkg::DEN_W
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] num_r [NUM_W];
  logic [NUM_W-1:0] quo_r [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] num_in;
    logic [NUM_W-1:0] quo_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W-1:0] rem_nxt;
    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_rest
      assign rem_in = rem_r[k-1];
      assign num_in = num_r[k-1];
      assign quo_in = quo_r[k-1];
      assign den_in = den_r[k-1];
    end
    always_comb begin
      trial   = {rem_in, num_in[NUM_W-1]};
      ge      = trial >= {1'b0, den_in};
      rem_nxt = ge ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        num_r[k] <= {num_in[NUM_W-2:0], 1'b0};
        quo_r[k] <= {quo_in[NUM_W-2:0], ge};
        den_r[k] <= den_in;
      end
    end
  end

  assign quo = quo_r[NUM_W-1];
endmodule

[rtl/lateral_safe_distance_check.sv]
`timescale 1ns / 1ps
// Channel | Direction | Ports
// in      | input     | in_valid, in_ready, in_lat_vel_first .. in_max_acc_second
// out     | output    | out_valid, out_ready, out_is_safe, out_decision_path
// cfg     | input     | cfg_valid, cfg_ready, cfg_index, cfg_data
// One word enters per cycle while the output is not stalled; each result passes the input
// registers, the operand registers, two 31-stage restoring dividers for the square terms and the output register.
// Reset clears all valid bits and loads both response times with 256.
// A stalled output freezes the whole pipeline; in_ready is low only then.
`include "lateral_safe_distance_check_defines.svh"
module lateral_safe_distance_check (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [lsdc_pkg::VEL_W-1:0]   in_lat_vel_first,
  input  logic signed [lsdc_pkg::VEL_W-1:0]   in_lat_vel_second,
  input  logic signed [lsdc_pkg::GAP_W-1:0]   in_lat_gap,
  input  logic        [lsdc_pkg::ACC_W-1:0]   in_max_acc_first,
  input  logic        [lsdc_pkg::ACC_W-1:0]   in_max_acc_second,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_is_safe,
  output logic        [1:0]                   out_decision_path,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic        [lsdc_pkg::RT_W-1:0]    cfg_data
);
  import lsdc_pkg::*;

  logic en;
  logic [RT_W-1:0] rt_other_r, rt_ego_r;

  logic s1_valid_r;
  logic signed [VEL_W-1:0] v1_r, v2_r;
  logic [ACC_W-1:0] a1_r, a2_r;
  logic [RT_W-1:0] t1_r, t2_r;
  side_t s1_side_r, s1_side_nxt;
  logic signed [VEL_W-1:0] v1_nxt, v2_nxt;
  logic [ACC_W-1:0] a1_nxt, a2_nxt;
  logic [RT_W-1:0] t1_nxt, t2_nxt;

  logic s2_valid_r;
  side_t s2_side_r, s2_side_nxt;
  logic [SQ_W-1:0] n1_r, n2_r;
  logic [DEN_W-1:0] d1_r, d2_r;
  logic signed [PROD_W-1:0] p1, p2;
  logic signed [2*VEL_W-1:0] q1, q2;

  logic dv_r [SQ_W];
  side_t ds_r [SQ_W];
  logic [SQ_W-1:0] quo1, quo2;

  logic out_valid_r, out_is_safe_r;
  path_t out_path_r;
  logic [SQ_W-1:0] sq1, sq2;
  logic signed [NEED_W-1:0] need;
  side_t fs;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_other_r <= RT_RESET;
      rt_ego_r   <= RT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RT_OTHER: rt_other_r <= cfg_data;
        CFG_RT_EGO:   rt_ego_r   <= cfg_data;
        default:      rt_ego_r   <= rt_ego_r;
      endcase
    end
  end

  always_comb begin
    logic swap;
    swap   = in_lat_vel_first < in_lat_vel_second;
    v1_nxt = swap ? in_lat_vel_second : in_lat_vel_first;
    v2_nxt = swap ? in_lat_vel_first : in_lat_vel_second;
    a1_nxt = swap ? in_max_acc_second : in_max_acc_first;
    a2_nxt = swap ? in_max_acc_first : in_max_acc_second;
    t1_nxt = swap ? rt_ego_r : rt_other_r;
    t2_nxt = swap ? rt_other_r : rt_ego_r;
    s1_side_nxt = '0;
    s1_side_nxt.mag = in_lat_gap[GAP_W-1] ? MAG_W'(-in_lat_gap) : MAG_W'(in_lat_gap);
    if (in_lat_gap == '0) begin
      s1_side_nxt.path = PATH_ZERO;
      s1_side_nxt.safe = 1'b0;
    end else if ((!in_lat_vel_first[VEL_W-1] && (in_lat_vel_second[VEL_W-1] ||
                  in_lat_vel_second == '0) && in_lat_gap[GAP_W-1]) ||
                 ((in_lat_vel_first[VEL_W-1] || in_lat_vel_first == '0) &&
                  !in_lat_vel_second[VEL_W-1] && !in_lat_gap[GAP_W-1])) begin
      s1_side_nxt.path = PATH_APART;
      s1_side_nxt.safe = 1'b1;
    end else begin
      s1_side_nxt.path = PATH_FORMULA;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      a1_r <= a1_nxt;
      a2_r <= a2_nxt;
      t1_r <= t1_nxt;
      t2_r <= t2_nxt;
      s1_side_r <= s1_side_nxt;
    end
  end

  always_comb begin
    p1 = PROD_W'(v1_r) * $signed({1'b0, t1_r});
    p2 = PROD_W'(v2_r) * $signed({1'b0, t2_r});
    q1 = v1_r * v1_r;
    q2 = v2_r * v2_r;
    s2_side_nxt     = s1_side_r;
    s2_side_nxt.vt1 = VT_W'((p1 + (p1[PROD_W-1] ? PROD_W'(255) : PROD_W'(0))) >>> 8);
    s2_side_nxt.vt2 = VT_W'((p2 + (p2[PROD_W-1] ? PROD_W'(255) : PROD_W'(0))) >>> 8);
    s2_side_nxt.zv1 = v1_r == '0;
    s2_side_nxt.zv2 = v2_r == '0;
    s2_side_nxt.za1 = a1_r == '0;
    s2_side_nxt.za2 = a2_r == '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side_r <= s2_side_nxt;
      n1_r <= SQ_W'(q1);
      n2_r <= SQ_W'(q2);
      d1_r <= {a1_r, 1'b0};
      d2_r <= {a2_r, 1'b0};
    end
  end

  lsdc_div #(.NUM_W(SQ_W), .DEN_W(DEN_W)) u_div1 (
    .clk(clk), .en(en), .num(n1_r), .den(d1_r), .quo(quo1)
  );
  lsdc_div #(.NUM_W(SQ_W), .DEN_W(DEN_W)) u_div2 (
    .clk(clk), .en(en), .num(n2_r), .den(d2_r), .quo(quo2)
  );

  for (genvar k = 0; k < SQ_W; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else if (en) begin
        dv_r[k] <= (k == 0) ? s2_valid_r : dv_r[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ds_r[k] <= (k == 0) ? s2_side_r : ds_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_comb begin
    fs   = ds_r[SQ_W-1];
    sq1  = fs.zv1 ? '0 : (fs.za1 ? TERM_MAX : quo1);
    sq2  = fs.zv2 ? '0 : (fs.za2 ? TERM_MAX : quo2);
    need = NEED_W'(fs.vt1) + $signed({2'b00, sq1}) - NEED_W'(fs.vt2)
         + $signed({2'b00, sq2});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= in_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= dv_r[SQ_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_path_r <= fs.path;
      if (fs.path == PATH_FORMULA) begin
        out_is_safe_r <= $signed({1'b0, NEED_W'(fs.mag)}) > $signed({need[NEED_W-1], need});
      end else begin
        out_is_safe_r <= fs.safe;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_is_safe       = out_is_safe_r;
  assign out_decision_path = out_path_r;

  `LSDC_ASSERT_IMP(a_zero_unsafe, clk, rst_n, out_valid_r && out_path_r == PATH_ZERO, !out_is_safe_r)
  `LSDC_ASSERT_IMP(a_apart_safe, clk, rst_n, out_valid_r && out_path_r == PATH_APART, out_is_safe_r)
  `LSDC_ASSERT_IMP(a_stall_blocks, clk, rst_n, out_valid_r && !out_ready, !in_ready)
  `LSDC_ASSERT_NXT(a_stall_holds, clk, rst_n, out_valid_r && !out_ready, $stable(out_path_r))
endmodule
